// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a named clock with an active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the default clock and reset names
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Types and codes of the packed array engine.
// ----------------------------------------------------------------------------
package pae_pkg;

  // command codes
  localparam logic [3:0] CMD_INS = 4'd0;
  localparam logic [3:0] CMD_DEL = 4'd1;
  localparam logic [3:0] CMD_GET = 4'd2;
  localparam logic [3:0] CMD_SET = 4'd3;
  localparam logic [3:0] CMD_LIN = 4'd4;
  localparam logic [3:0] CMD_BIN = 4'd5;
  localparam logic [3:0] CMD_MAX = 4'd6;
  localparam logic [3:0] CMD_MIN = 4'd7;
  localparam logic [3:0] CMD_SUM = 4'd8;
  localparam logic [3:0] CMD_AVG = 4'd9;
  localparam logic [3:0] CMD_REV = 4'd10;

  // status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  localparam logic [6:0] CAP_RESET = 7'd64;
  localparam int unsigned VAL_W = 39;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [5:0]         position;
    logic signed [31:0] data;
  } pae_in_t;

  typedef struct packed {
    logic signed [38:0] result_value;
    logic [5:0]         result_index;
    logic [2:0]         status;
  } pae_out_t;

endpackage

// File: src/pae_mem.sv
// ----------------------------------------------------------------------------
// pae_mem
// Element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pae_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // write beat
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pae_div.sv
// ----------------------------------------------------------------------------
// pae_div
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pae_div #(
  parameter int unsigned NW = 39,
  parameter int unsigned DW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] dividend_i,
  input  logic [DW-1:0]        divisor_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [DW:0]     rem_q, rem_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;

  assign rem_sh  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // one step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[NW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[NW-1];
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub;
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: src/packed_array_engine.sv
// ----------------------------------------------------------------------------
// packed_array_engine
// Packed array of signed words with insert, delete, search and reductions.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on in_valid_i/in_ready_o, one result beat leaves on
//   out_valid_o/out_ready_i for every command. in_ready_o is high only while
//   the sequencer is idle; one command is worked on at a time.
//   The element store has a single read port with registered data, so each
//   element visited takes a read state and then a use state. Insert moves
//   the entries from the position up by one and then writes the new word,
//   delete shifts the entries behind it down, reductions visit every entry,
//   linear search stops at a hit, reverse swaps the entries pair by pair
//   and binary search probes until it hits or its bounds cross. Average
//   then runs the one-bit-per-cycle divider (NW = 33 + log2(DEPTH)).
//   Get reads one entry, set writes one; refused commands go straight out.
//   The capacity register is written by cfg_we_i/cfg_data_i without a wait.
//   Reset empties the array (count zero) and sets the capacity to 64; no
//   clearing pass is needed. A finished result sits in an output register;
//   while the receiver stalls, the next command may be accepted and the
//   sequencer holds its result until the output register frees.
// ----------------------------------------------------------------------------
module packed_array_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pae_pkg::pae_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pae_pkg::pae_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_data_i
);

  import pae_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > 7) ? CW : 7) + 1;
  localparam int unsigned SW   = 33 + $clog2(DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_USE  = 4'd2;
  localparam logic [3:0] S_BS   = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_RV2  = 4'd5;
  localparam logic [3:0] S_RV3  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [3:0]           cmd_q, cmd_d;
  logic [5:0]           pos_q, pos_d;
  logic signed [31:0]   key_q, key_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic signed [CW:0]   lo_q, lo_d, hi_q, hi_d;
  logic signed [SW-1:0] acc_q, acc_d;
  logic [31:0]          tmp_q, tmp_d;
  logic signed [38:0]   val_q, val_d;
  logic [5:0]           idx_q, idx_d;
  logic [2:0]           st_q, st_d;
  logic [6:0]           cap_q;
  pae_out_t             out_q;
  logic                 out_valid_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [31:0]          mem_wdata, mem_rdata;
  logic                 div_start, div_done;
  logic signed [SW-1:0] div_quo;

  logic [CMPW-1:0]      cnt_x, posin_x, pos_x, n_x, ptr_x, cap_x, capeff_x;
  logic [AW-1:0]        rev_j;
  logic signed [SW-1:0] word_ext;
  logic signed [CW+1:0] mid_sum;
  logic signed [CW:0]   ptr_s;
  logic signed [SW+38:0] quo_wide;
  logic [AW+5:0]        ptr_wide;
  logic                 out_free;

  // widened views for compares
  assign cnt_x    = {{(CMPW-CW){1'b0}}, count_q};
  assign posin_x  = {{(CMPW-6){1'b0}}, in_data_i.position};
  assign pos_x    = {{(CMPW-6){1'b0}}, pos_q};
  assign n_x      = {{(CMPW-CW){1'b0}}, n_q};
  assign ptr_x    = {{(CMPW-AW){1'b0}}, ptr_q};
  assign cap_x    = {{(CMPW-7){1'b0}}, cap_q};
  assign capeff_x = (cap_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_x;
  assign rev_j    = AW'(n_x - ptr_x - CMPW'(1));
  assign word_ext = {{(SW-32){mem_rdata[31]}}, mem_rdata};
  assign mid_sum  = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};
  assign ptr_s    = {{(CW+1-AW){1'b0}}, ptr_q};
  assign quo_wide = {{39{div_quo[SW-1]}}, div_quo};
  assign ptr_wide = {6'b0, ptr_q};
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign mem_raddr  = (state_q == S_USE && cmd_q == CMD_REV) ? rev_j : ptr_q;
  assign div_start  = (state_q == S_USE) && (cmd_q == CMD_AVG) &&
                      (ptr_x + CMPW'(1) >= n_x);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    key_d     = key_q;
    n_d       = n_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    tmp_d     = tmp_q;
    val_d     = val_q;
    idx_d     = idx_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = mem_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i.cmd;
          pos_d = in_data_i.position;
          key_d = in_data_i.data;
          n_d   = count_q;
          ptr_d = '0;
          acc_d = '0;
          val_d = '0;
          idx_d = '0;
          st_d  = ST_OK;
          state_d = S_OUT;
          unique case (in_data_i.cmd)
            CMD_INS: begin
              if (cnt_x >= capeff_x) begin
                st_d = ST_FULL;
              end else if (posin_x > cnt_x) begin
                st_d = ST_RANGE;
              end else if (posin_x == cnt_x) begin
                state_d = S_WB;
              end else begin
                ptr_d   = AW'(cnt_x - CMPW'(1));
                state_d = S_RD;
              end
            end
            CMD_DEL, CMD_GET: begin
              if (posin_x >= cnt_x) begin
                st_d = ST_RANGE;
              end else begin
                ptr_d   = AW'(posin_x);
                state_d = S_RD;
              end
            end
            CMD_SET: begin
              if (posin_x >= cnt_x) begin
                st_d = ST_RANGE;
              end else begin
                state_d = S_WB;
              end
            end
            CMD_LIN: begin
              if (count_q == '0) begin
                st_d = ST_MISS;
              end else begin
                state_d = S_RD;
              end
            end
            CMD_BIN: begin
              st_d    = ST_MISS;
              lo_d    = '0;
              hi_d    = {1'b0, count_q} - 1'b1;
              state_d = S_BS;
            end
            CMD_MAX, CMD_MIN, CMD_SUM, CMD_AVG: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                state_d = S_RD;
              end
            end
            CMD_REV: begin
              if (cnt_x >= CMPW'(2)) begin
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_USE;
      end
      S_USE: begin
        state_d = S_RD;
        unique case (cmd_q)
          CMD_INS: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q + 1'b1;
            if (ptr_x == pos_x) begin
              state_d = S_WB;
            end else begin
              ptr_d = ptr_q - 1'b1;
            end
          end
          CMD_DEL: begin
            if (ptr_x == pos_x) begin
              val_d = {{7{mem_rdata[31]}}, mem_rdata};
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ptr_q - 1'b1;
            end
            if (ptr_x + CMPW'(1) >= n_x) begin
              count_d = n_q - 1'b1;
              state_d = S_OUT;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
          CMD_GET: begin
            val_d   = {{7{mem_rdata[31]}}, mem_rdata};
            state_d = S_OUT;
          end
          CMD_LIN: begin
            if ($signed(mem_rdata) == key_q) begin
              idx_d   = ptr_wide[5:0];
              state_d = S_OUT;
            end else if (ptr_x + CMPW'(1) >= n_x) begin
              st_d    = ST_MISS;
              state_d = S_OUT;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
          CMD_BIN: begin
            state_d = S_BS;
            if ($signed(mem_rdata) == key_q) begin
              idx_d   = ptr_wide[5:0];
              st_d    = ST_OK;
              state_d = S_OUT;
            end else if (key_q < $signed(mem_rdata)) begin
              hi_d = ptr_s - 1'b1;
            end else begin
              lo_d = ptr_s + 1'b1;
            end
          end
          CMD_MAX, CMD_MIN, CMD_SUM, CMD_AVG: begin
            // shared compare / add unit
            if (cmd_q == CMD_SUM || cmd_q == CMD_AVG) begin
              acc_d = acc_q + word_ext;
            end else if (ptr_q == '0) begin
              acc_d = word_ext;
            end else if (cmd_q == CMD_MAX ? (word_ext > acc_q) : (word_ext < acc_q)) begin
              acc_d = word_ext;
            end
            if (ptr_x + CMPW'(1) >= n_x) begin
              state_d = (cmd_q == CMD_AVG) ? S_DIV : S_OUT;
              if (cmd_q != CMD_AVG) begin
                val_d = 39'(acc_d);
              end
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
          CMD_REV: begin
            tmp_d   = mem_rdata;
            state_d = S_RV2;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_RV2: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        state_d   = S_RV3;
      end
      S_RV3: begin
        mem_we    = 1'b1;
        mem_waddr = rev_j;
        mem_wdata = tmp_q;
        if (ptr_x + CMPW'(1) >= (n_x >> 1)) begin
          state_d = S_OUT;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_BS: begin
        if (lo_q > hi_q) begin
          state_d = S_OUT;
        end else begin
          ptr_d   = AW'(mid_sum >>> 1);
          state_d = S_RD;
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_x);
        mem_wdata = key_q;
        if (cmd_q == CMD_INS) begin
          count_d = n_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          val_d   = quo_wide[38:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and output beat
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pos_q <= pos_d;
    key_q <= key_d;
    n_q   <= n_d;
    ptr_q <= ptr_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    val_q <= val_d;
    idx_q <= idx_d;
    st_q  <= st_d;
    if (state_q == S_OUT && out_free) begin
      out_q.result_value <= val_q;
      out_q.result_index <= idx_q;
      out_q.status       <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pae_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pae_div #(
    .NW (SW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

// File: src/pae_checker.sv
// ----------------------------------------------------------------------------
// pae_checker
// Port-level checks of the packed array engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pae_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input pae_pkg::pae_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pae_pkg::pae_out_t out_data_o,
  input logic              cfg_we_i,
  input logic [6:0]        cfg_data_i
);

  import pae_pkg::*;

  // the sequencer is busy the cycle after a command beat
  `ASSERT_DEF(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")

  // a stalled result beat holds
  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed under stall")

  // status stays within its codes
  `ASSERT_DEF(a_status_code, out_valid_o |-> out_data_o.status <= ST_EMPTY, "bad status code")

  // refused commands carry zero fields
  `ASSERT_DEF(a_fail_zero, out_valid_o && out_data_o.status != ST_OK |-> out_data_o.result_value == 0 && out_data_o.result_index == 0, "non-zero fields on failure")

endmodule

bind packed_array_engine pae_checker u_pae_checker (.*);
